// ===== hdl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the gradient stroke angle block
// Luminance weights, fixed-point widths, the arctangent step table and the
// record that travels down the rotation chain.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned RGB_W  = 8;
  localparam int unsigned LUMA_W = 24;   // 255 * 65536 fits in 24 bits
  localparam int unsigned DIFF_W = 25;   // signed difference of two lumas
  localparam int unsigned XY_W   = 28;   // vector components with CORDIC growth
  localparam int unsigned Z_W    = 30;   // accumulated angle, Q20 degrees
  localparam int unsigned DEG_FRAC = 20;
  localparam int unsigned DEG_W  = 9;

  localparam int unsigned ATAN_TABLE_LEN       = 24;
  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;

  localparam logic [LUMA_W-1:0] LUMA_WR = 24'd13933;
  localparam logic [LUMA_W-1:0] LUMA_WG = 24'd46871;
  localparam logic [LUMA_W-1:0] LUMA_WB = 24'd4732;

  localparam logic [DEG_W-1:0] DEG_0      = 9'd0;
  localparam logic [DEG_W-1:0] DEG_90     = 9'd90;
  localparam logic [DEG_W-1:0] DEG_180    = 9'd180;
  localparam logic [DEG_W-1:0] DEG_270    = 9'd270;
  localparam logic [DEG_W-1:0] DEG_MAX    = 9'd359;
  localparam logic [DEG_W-1:0] STROKE_OFF = 9'd90;

  localparam logic signed [Z_W-1:0] HALF_TURN_Q20 = Z_W'(180 * (1 << DEG_FRAC));
  localparam logic signed [Z_W-1:0] FULL_TURN_Q20 = Z_W'(360 * (1 << DEG_FRAC));

  // Record handed from one rotation cell to the next.
  typedef struct packed {
    logic                   held;       // zero gradient, repeat the last angle
    logic                   fixed;      // axis direction, angle known exactly
    logic [DEG_W-1:0]       fixed_deg;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } gsa_stage_t;

  // Luminance in units of 1/65536.
  function automatic logic [LUMA_W-1:0] luma(input logic [RGB_W-1:0] r,
                                             input logic [RGB_W-1:0] g,
                                             input logic [RGB_W-1:0] b);
    return LUMA_WR * LUMA_W'(r) + LUMA_WG * LUMA_W'(g) + LUMA_WB * LUMA_W'(b);
  endfunction

  // atan(2^-i) in degrees, scaled by 2^20 and rounded.
  function automatic logic [26:0] atan_q20(input logic [4:0] i);
    logic [26:0] v;
    case (i)
      5'd0:    v = 27'd47185920;
      5'd1:    v = 27'd27855475;
      5'd2:    v = 27'd14718068;
      5'd3:    v = 27'd7471121;
      5'd4:    v = 27'd3750058;
      5'd5:    v = 27'd1876857;
      5'd6:    v = 27'd938658;
      5'd7:    v = 27'd469357;
      5'd8:    v = 27'd234682;
      5'd9:    v = 27'd117342;
      5'd10:   v = 27'd58671;
      5'd11:   v = 27'd29335;
      5'd12:   v = 27'd14668;
      5'd13:   v = 27'd7334;
      5'd14:   v = 27'd3667;
      5'd15:   v = 27'd1833;
      5'd16:   v = 27'd917;
      5'd17:   v = 27'd458;
      5'd18:   v = 27'd229;
      5'd19:   v = 27'd115;
      5'd20:   v = 27'd57;
      5'd21:   v = 27'd29;
      5'd22:   v = 27'd14;
      5'd23:   v = 27'd7;
      default: v = 27'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/gsa_prep.sv =====
// ----------------------------------------------------------------------------
// gsa_prep: luminance and vector set-up
// Registers the four luminances, then forms the gradient, detects the zero
// and axis cases and folds the left half-plane onto the right.
// ----------------------------------------------------------------------------
module gsa_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         load_i,
  input  logic [7:0]                   north_red_i,
  input  logic [7:0]                   north_green_i,
  input  logic [7:0]                   north_blue_i,
  input  logic [7:0]                   south_red_i,
  input  logic [7:0]                   south_green_i,
  input  logic [7:0]                   south_blue_i,
  input  logic [7:0]                   east_red_i,
  input  logic [7:0]                   east_green_i,
  input  logic [7:0]                   east_blue_i,
  input  logic [7:0]                   west_red_i,
  input  logic [7:0]                   west_green_i,
  input  logic [7:0]                   west_blue_i,
  output logic                         valid_o,
  output gsa_pkg::gsa_stage_t          stage_o
);
  import gsa_pkg::*;

  logic              luma_valid_q;
  logic [LUMA_W-1:0] ln_q, ls_q, le_q, lw_q;
  logic              valid_q;
  gsa_stage_t        stage_d, stage_q;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [XY_W-1:0]   xe, ye;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else if (adv_i) begin
      luma_valid_q <= load_i;
      valid_q      <= luma_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ln_q <= luma(north_red_i, north_green_i, north_blue_i);
      ls_q <= luma(south_red_i, south_green_i, south_blue_i);
      le_q <= luma(east_red_i, east_green_i, east_blue_i);
      lw_q <= luma(west_red_i, west_green_i, west_blue_i);
    end
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign dy = $signed({1'b0, ln_q}) - $signed({1'b0, ls_q});
  assign dx = $signed({1'b0, le_q}) - $signed({1'b0, lw_q});
  assign xe = XY_W'(dx);
  assign ye = XY_W'(dy);

  always_comb begin
    stage_d           = '0;
    stage_d.held      = (dx == '0) && (dy == '0);
    stage_d.fixed     = (dx == '0) || (dy == '0);
    if (dy == '0) begin
      stage_d.fixed_deg = (dx > 0) ? DEG_0 : DEG_180;
    end else begin
      stage_d.fixed_deg = (dy > 0) ? DEG_90 : DEG_270;
    end
    // A vector in the left half-plane is turned through half a turn.
    if (dx < 0) begin
      stage_d.x = -xe;
      stage_d.y = -ye;
      stage_d.z = HALF_TURN_Q20;
    end else begin
      stage_d.x = xe;
      stage_d.y = ye;
      stage_d.z = '0;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== hdl/gsa_cell.sv =====
// ----------------------------------------------------------------------------
// gsa_cell: one CORDIC vectoring rotation
// Rotates the vector towards the x axis by atan(2^-SHIFT) and registers it.
// ----------------------------------------------------------------------------
module gsa_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  gsa_pkg::gsa_stage_t stage_i,
  output logic                valid_o,
  output gsa_pkg::gsa_stage_t stage_o
);
  import gsa_pkg::*;

  localparam logic signed [Z_W-1:0] Step = Z_W'(atan_q20(5'(SHIFT)));

  logic signed [XY_W-1:0] x_in, y_in, xs, ys;
  logic                   valid_q;
  gsa_stage_t             stage_d, stage_q;

  assign x_in = stage_i.x;
  assign y_in = stage_i.y;
  assign xs   = x_in >>> SHIFT;
  assign ys   = y_in >>> SHIFT;

  always_comb begin
    stage_d = stage_i;
    if (!y_in[XY_W-1]) begin
      stage_d.x = x_in + ys;
      stage_d.y = y_in - xs;
      stage_d.z = stage_i.z + Step;
    end else begin
      stage_d.x = x_in - ys;
      stage_d.y = y_in + xs;
      stage_d.z = stage_i.z - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== hdl/gradient_stroke_angle.sv =====
// ----------------------------------------------------------------------------
// gradient_stroke_angle: stroke direction from the luminance gradient
// Rec.709 luminance of four neighbours, atan2 of the gradient by a chain of
// CORDIC cells, and a stroke angle perpendicular to the gradient.
// ----------------------------------------------------------------------------
// The block takes the colours of the four neighbours of a pixel and returns
// one transfer per item: the stroke angle in whole degrees (gradient angle
// plus 90, from 90 to 449, not wrapped) and a flag that is set when the
// gradient was zero and the previous angle is repeated (0 straight after
// reset). From its input transfer to the result showing on the output, an
// item passes the luminance registers, loaded at the input transfer itself,
// then the vector set-up register, each rotation cell in turn and the output
// register into which the angle is finished. One item is in flight at a
// time, so the next item is taken only once the result has been registered.
// A waiting result does not block the next item; only a result that is
// ready to leave the chain while the output register is still stalled
// freezes the chain.
// ----------------------------------------------------------------------------
module gradient_stroke_angle #(
  parameter int unsigned ANGLE_ITERATIONS = gsa_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] north_red_i,
  input  logic [7:0] north_green_i,
  input  logic [7:0] north_blue_i,
  input  logic [7:0] south_red_i,
  input  logic [7:0] south_green_i,
  input  logic [7:0] south_blue_i,
  input  logic [7:0] east_red_i,
  input  logic [7:0] east_green_i,
  input  logic [7:0] east_blue_i,
  input  logic [7:0] west_red_i,
  input  logic [7:0] west_green_i,
  input  logic [7:0] west_blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [8:0] stroke_angle_o,
  output logic       angle_held_o
);
  import gsa_pkg::*;

  // Control state: an item is in flight from its input transfer until its
  // result has been written into the output register.
  logic busy_q;
  logic accept;
  logic adv;
  logic finish;

  // The rotation chain: position 0 is the set-up register, position k + 1
  // the output of rotation cell k.
  logic [ANGLE_ITERATIONS:0] valid_s;
  gsa_stage_t                stage_s [ANGLE_ITERATIONS+1];

  // Output register and the angle reported for a zero gradient.
  logic             out_valid_q;
  logic [DEG_W-1:0] stroke_q, stroke_d;
  logic             held_q, held_d;
  logic [DEG_W-1:0] last_angle_q;

  gsa_stage_t              tail;
  logic signed [Z_W-1:0]   ang_adj;
  logic [Z_W-DEG_FRAC-1:0] ang_whole;
  logic [DEG_W-1:0]        grad_deg;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  // The chain only stops when the finished item cannot enter the output.
  assign adv    = !(valid_s[ANGLE_ITERATIONS] && out_valid_q && out_stall_i);
  assign finish = valid_s[ANGLE_ITERATIONS] && adv;

  gsa_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .load_i        (accept),
    .north_red_i   (north_red_i),
    .north_green_i (north_green_i),
    .north_blue_i  (north_blue_i),
    .south_red_i   (south_red_i),
    .south_green_i (south_green_i),
    .south_blue_i  (south_blue_i),
    .east_red_i    (east_red_i),
    .east_green_i  (east_green_i),
    .east_blue_i   (east_blue_i),
    .west_red_i    (west_red_i),
    .west_green_i  (west_green_i),
    .west_blue_i   (west_blue_i),
    .valid_o       (valid_s[0]),
    .stage_o       (stage_s[0])
  );

  for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cell
    gsa_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_s[k]),
      .stage_i (stage_s[k]),
      .valid_o (valid_s[k+1]),
      .stage_o (stage_s[k+1])
    );
  end

  // Finishing: bring a negative angle into range, floor to whole degrees
  // and cap at 359. Axis directions use their exact angle, not the rotations.
  assign tail      = stage_s[ANGLE_ITERATIONS];
  assign ang_adj   = tail.z[Z_W-1] ? tail.z + FULL_TURN_Q20 : tail.z;
  assign ang_whole = ang_adj[Z_W-1:DEG_FRAC];

  always_comb begin
    if (tail.fixed) begin
      grad_deg = tail.fixed_deg;
    end else if (ang_adj[Z_W-1]) begin
      grad_deg = DEG_0;
    end else if (ang_whole > (Z_W-DEG_FRAC)'(DEG_MAX)) begin
      grad_deg = DEG_MAX;
    end else begin
      grad_deg = ang_whole[DEG_W-1:0];
    end

    // A zero gradient repeats the last stroke angle and leaves it as it is.
    if (tail.held) begin
      stroke_d = last_angle_q;
      held_d   = 1'b1;
    end else begin
      stroke_d = grad_deg + STROKE_OFF;
      held_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      last_angle_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (finish && !tail.held) begin
        last_angle_q <= stroke_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      stroke_q <= stroke_d;
      held_q   <= held_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stroke_angle_o = stroke_q;
  assign angle_held_o   = held_q;

endmodule
